// ----- hdl/polyphase_linear_resampler_assert.svh -----
`ifndef POLYPHASE_LINEAR_RESAMPLER_ASSERT_SVH
`define POLYPHASE_LINEAR_RESAMPLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PLR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PLR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/plr_pkg.sv -----
package plr_pkg;

	localparam int PHASES_DEF = 10;
	localparam int TAPS_DEF   = 12;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 18;
	localparam int TAP_ADDR_W = 7;
	localparam int STEP_W     = 22;
	localparam int FRAC_W     = 16;

	localparam int RES_MAX = 32767;
	localparam int RES_MIN = -32768;

	// results per sample are capped
	localparam int MAX_OUT   = 4;
	localparam int RUN_CNT_W = $clog2(MAX_OUT + 1);

	localparam logic [STEP_W-1:0] STEP_RESET = 22'd655360;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TAP    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic coef_wr;
		logic hist_shift;
		logic start;
		logic last_hint;
		logic fetch;
		logic mul;
		logic sum;
		logic emit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic time_lt_end;
		logic tap_done;
		logic out_free;
	} status_t;

endpackage

// ----- hdl/polyphase_linear_resampler.sv -----
// Coefficient transfer: written with the input side kept open, next item taken the cycle after.
// Sample transfer: each result runs a serial tap loop over two coefficient read ports and
// two MACs, then a split interpolation multiply; the input side stays closed for the whole
// run, at most 4 results per sample. Output register frees the result side.
// arst_n clears history to zero, time to TAPS_PER_PHASE * PHASES, step to its default.
module polyphase_linear_resampler #(
	parameter int PHASES         = plr_pkg::PHASES_DEF,
	parameter int TAPS_PER_PHASE = plr_pkg::TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                kind,
	input  logic signed [plr_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [plr_pkg::TAP_ADDR_W-1:0]      tap_address,
	input  logic signed [plr_pkg::COEF_W-1:0]   tap_value,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [plr_pkg::SAMPLE_W-1:0] resampled_value,
	output logic                                last_of_run,
	input  logic                                cfg_write_en,
	input  logic [plr_pkg::STEP_W-1:0]          cfg_write_data
);
	import plr_pkg::*;

	cmd_t    cmd;
	status_t status;

	plr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.item_ready (item_ready),
		.cmd        (cmd),
		.status     (status)
	);

	plr_datapath #(
		.PHASES (PHASES),
		.TAPS   (TAPS_PER_PHASE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.sample_value    (sample_value),
		.tap_address     (tap_address),
		.tap_value       (tap_value),
		.result_ready    (result_ready),
		.result_valid    (result_valid),
		.resampled_value (resampled_value),
		.last_of_run     (last_of_run)
	);

endmodule

// ----- hdl/plr_ctrl.sv -----
module plr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            kind,
	output logic            item_ready,
	output plr_pkg::cmd_t   cmd,
	input  plr_pkg::status_t status
);
	import plr_pkg::*;

	state_t                 state_q, state_d;
	logic [RUN_CNT_W-1:0]   n_q, n_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (kind == KIND_TAP) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.hist_shift = 1'b1;
						n_d            = '0;
						state_d        = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (status.time_lt_end && (n_q < RUN_CNT_W'(MAX_OUT))) begin
					cmd.start     = 1'b1;
					cmd.last_hint = (n_q == RUN_CNT_W'(MAX_OUT - 1));
					state_d       = ST_RUN;
				end else begin
					// run over: move time back by one input sample
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_RUN: begin
				cmd.fetch = 1'b1;
				if (status.tap_done) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					n_d      = n_q + RUN_CNT_W'(1);
					state_d  = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/plr_datapath.sv -----
module plr_datapath #(
	parameter int PHASES = plr_pkg::PHASES_DEF,
	parameter int TAPS   = plr_pkg::TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plr_pkg::cmd_t                       cmd,
	output plr_pkg::status_t                    status,
	input  logic                                cfg_write_en,
	input  logic [plr_pkg::STEP_W-1:0]          cfg_write_data,
	input  logic signed [plr_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [plr_pkg::TAP_ADDR_W-1:0]      tap_address,
	input  logic signed [plr_pkg::COEF_W-1:0]   tap_value,
	input  logic                                result_ready,
	output logic                                result_valid,
	output logic signed [plr_pkg::SAMPLE_W-1:0] resampled_value,
	output logic                                last_of_run
);
	import plr_pkg::*;

	localparam int HIST_LEN  = TAPS + 1;
	localparam int TABLE_LEN = PHASES * TAPS;
	localparam int ADDR_W    = $clog2(TABLE_LEN);
	localparam int HIST_W    = $clog2(HIST_LEN);
	localparam int REL_W     = $clog2(PHASES);
	localparam int CMP_W     = (ADDR_W > TAP_ADDR_W) ? ADDR_W : TAP_ADDR_W;

	localparam int START_INT = TAPS * PHASES * (2 ** FRAC_W);
	localparam int END_INT   = (TAPS + 1) * PHASES * (2 ** FRAC_W);
	localparam int DROP_INT  = PHASES * (2 ** FRAC_W);
	localparam int MSTEP_INT = PHASES * (2 ** (FRAC_W - 2));
	localparam int TIME_W    = $clog2(END_INT + (2 ** STEP_W));
	localparam int K_W       = TIME_W - FRAC_W;

	localparam int PROD_W    = COEF_W + SAMPLE_W;
	localparam int ACC_W     = PROD_W + 1 + $clog2(TAPS);
	localparam int LO_W      = 24;
	localparam int HI_W      = ACC_W - LO_W;
	localparam int LO_P_W    = LO_W + FRAC_W;
	localparam int HI_P_W    = HI_W + FRAC_W + 1;
	localparam int SUM_W     = ACC_W + FRAC_W + 3;
	localparam int RND_SH    = 2 * FRAC_W + 1;
	localparam int R_W       = SUM_W - RND_SH;

	localparam logic [TIME_W-1:0]        START_TIME = TIME_W'(START_INT);
	localparam logic [TIME_W-1:0]        END_TIME   = TIME_W'(END_INT);
	localparam logic [TIME_W-1:0]        TIME_DROP  = TIME_W'(DROP_INT);
	localparam logic [STEP_W-1:0]        MIN_STEP   = STEP_W'(MSTEP_INT);
	localparam logic [K_W-1:0]           K_BASE     = K_W'(TAPS * PHASES);
	localparam logic signed [SUM_W-1:0]  ROUND_C    = SUM_W'(1) <<< (RND_SH - 1);
	localparam logic signed [R_W-1:0]    R_MAX      = R_W'(RES_MAX);
	localparam logic signed [R_W-1:0]    R_MIN      = R_W'(RES_MIN);

	logic [STEP_W-1:0]               step_q;
	logic [TIME_W-1:0]               time_q;
	logic signed [SAMPLE_W-1:0]      hist_q [HIST_LEN];
	logic signed [COEF_W-1:0]        coef_mem [TABLE_LEN];

	logic [HIST_W-1:0]               j_q;
	logic [ADDR_W-1:0]               base1_q, base2_q;
	logic [FRAC_W-1:0]               frac_q;
	logic                            shift_q;
	logic                            last_q;

	logic signed [COEF_W-1:0]        c1_s1, c2_s1;
	logic signed [SAMPLE_W-1:0]      v_s1, vp_s1;
	logic                            tap_s1;
	logic signed [PROD_W-1:0]        p1_s2, p2_s2;
	logic                            tap_s2;
	logic signed [ACC_W-1:0]         y1_q, d_q;
	logic [LO_P_W-1:0]               lo_s3;
	logic signed [HI_P_W-1:0]        hi_s3;
	logic signed [SUM_W-1:0]         acc_q;

	logic                            res_valid_q;
	logic signed [SAMPLE_W-1:0]      res_value_q;
	logic                            res_last_q;

	logic [STEP_W-1:0]               step_eff;
	logic [TIME_W-1:0]               time_adv;
	logic [K_W-1:0]                  rel_full;
	logic [REL_W-1:0]                rel1;
	logic [ADDR_W-1:0]               base1_d;
	logic                            shift_d;
	logic [HIST_W-1:0]               hist_idx;
	logic [ADDR_W-1:0]               tap_idx;
	logic                            tap_en;
	logic                            wr_in_range;
	logic signed [R_W-1:0]           r_full;
	logic signed [SAMPLE_W-1:0]      r_sat;

	assign step_eff = (step_q < MIN_STEP) ? MIN_STEP : step_q;
	assign time_adv = time_q + TIME_W'(step_eff);

	// time index sits in the last input-sample interval, so phase is an offset
	assign rel_full = time_q[TIME_W-1:FRAC_W] - K_BASE;
	assign rel1     = rel_full[REL_W-1:0];
	assign base1_d  = ADDR_W'(rel1 * TAPS);
	assign shift_d  = (rel1 == REL_W'(PHASES - 1));

	assign hist_idx    = HIST_W'(TAPS) - j_q;
	assign tap_idx     = ADDR_W'(j_q - HIST_W'(1));
	assign tap_en      = cmd.fetch && (j_q != '0);
	assign wr_in_range = CMP_W'(tap_address) < CMP_W'(TABLE_LEN);

	assign status.time_lt_end = time_q < END_TIME;
	assign status.tap_done    = (j_q == HIST_W'(TAPS));
	assign status.out_free    = !res_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			time_q <= START_TIME;
		end else begin
			if (cfg_write_en) begin
				step_q <= cfg_write_data;
			end
			if (cmd.start) begin
				time_q <= time_adv;
			end else if (cmd.finish) begin
				time_q <= time_q - TIME_DROP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.hist_shift) begin
			for (int i = 0; i < HIST_LEN - 1; i++) begin
				hist_q[i] <= hist_q[i + 1];
			end
			hist_q[HIST_LEN - 1] <= sample_value;
		end
	end

	// coefficient table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && wr_in_range) begin
			coef_mem[ADDR_W'(tap_address)] <= tap_value;
		end
		if (tap_en) begin
			c1_s1 <= coef_mem[base1_q + tap_idx];
			c2_s1 <= coef_mem[base2_q + tap_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			if (cmd.start) begin
				j_q <= '0;
			end else if (cmd.fetch) begin
				j_q <= j_q + HIST_W'(1);
			end
			tap_s1 <= tap_en;
			tap_s2 <= tap_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			base1_q <= base1_d;
			base2_q <= shift_d ? '0 : base1_d + ADDR_W'(TAPS);
			shift_q <= shift_d;
			frac_q  <= time_q[FRAC_W-1:0];
			last_q  <= cmd.last_hint || !(time_adv < END_TIME);
		end
		// sample window walks from newest to oldest; vp_s1 is one place newer
		if (cmd.fetch) begin
			v_s1  <= hist_q[hist_idx];
			vp_s1 <= v_s1;
		end
		p1_s2 <= c1_s1 * v_s1;
		p2_s2 <= c2_s1 * (shift_q ? vp_s1 : v_s1);
		if (cmd.start) begin
			y1_q <= '0;
			d_q  <= '0;
		end else if (tap_s2) begin
			y1_q <= y1_q + ACC_W'(p1_s2);
			d_q  <= d_q + ACC_W'(p2_s2) - ACC_W'(p1_s2);
		end
		// (y2 - y1) * frac split in two partial products
		if (cmd.mul) begin
			lo_s3 <= d_q[LO_W-1:0] * frac_q;
			hi_s3 <= $signed(d_q[ACC_W-1:LO_W]) * $signed({1'b0, frac_q});
		end
		if (cmd.sum) begin
			acc_q <= (SUM_W'(y1_q) <<< FRAC_W) + (SUM_W'(hi_s3) <<< LO_W)
				+ SUM_W'(lo_s3) + ROUND_C;
		end
	end

	assign r_full = R_W'(acc_q >>> RND_SH);

	always_comb begin
		if (r_full > R_MAX) begin
			r_sat = SAMPLE_W'(R_MAX);
		end else if (r_full < R_MIN) begin
			r_sat = SAMPLE_W'(R_MIN);
		end else begin
			r_sat = SAMPLE_W'(r_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_value_q <= r_sat;
			res_last_q  <= last_q;
		end
	end

	assign result_valid    = res_valid_q;
	assign resampled_value = res_value_q;
	assign last_of_run     = res_last_q;

endmodule

// ----- hdl/plr_checker.sv -----
`include "polyphase_linear_resampler_assert.svh"

module plr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_ready,
	input logic                                kind,
	input logic                                result_valid,
	input logic                                result_ready,
	input logic signed [plr_pkg::SAMPLE_W-1:0] resampled_value,
	input logic                                last_of_run
);
	import plr_pkg::*;

	// stalled result holds
	`PLR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(resampled_value) && $stable(last_of_run), "result changed while stalled")

	// a sample transfer starts a run, so input side closes
	`PLR_ASSERT_NEXT(a_sample_busy, item_valid && item_ready && (kind == KIND_SAMPLE), !item_ready, "input open right after sample transfer")

	// a coefficient write does not close the input side
	`PLR_ASSERT_NEXT(a_tap_open, item_valid && item_ready && (kind == KIND_TAP), item_ready, "input closed after coefficient transfer")

	// new results only come out of a run in progress
	`PLR_ASSERT_NOW(a_result_in_run, $rose(result_valid), $past(!item_ready), "result appeared outside a run")

endmodule

bind polyphase_linear_resampler plr_checker u_plr_checker (.*);
